FILE: sv/lru_page_replacement_macros.svh
// Assertion helpers for the LRU page replacement block.
// Each check is sampled on clk and disabled while rst is high.
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define LRU_CHECK_NOW(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// Condition holds in the cycle after the trigger.
`define LRU_CHECK_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

FILE: sv/lru_pr_pkg.sv
package lru_pr_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int PAGE_W     = 8;
  localparam int FRAME_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int STAMP_W    = 16;
  localparam int COUNT_W    = 16;
  localparam int CFG_W      = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(MAX_FRAMES);

  // Clamp the frame count register into 1..MAX_FRAMES.
  function automatic logic [CNT_W-1:0] clamp_limit(input logic [CFG_W-1:0] cfg);
    logic [CNT_W-1:0] lim;
    if (cfg == '0) begin
      lim = CNT_W'(1);
    end else if (int'(cfg) > MAX_FRAMES) begin
      lim = CNT_W'(MAX_FRAMES);
    end else begin
      lim = CNT_W'(cfg);
    end
    return lim;
  endfunction

endpackage

FILE: sv/lru_pr_ram.sv
module lru_pr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/lru_page_replacement.sv
// LRU page replacement over a fully associative set of page frames.
// A reference scans frames 0..limit-1, then decides and writes the slot, where limit is
// frames_in_use clamped to 1..16; a new start is taken in the done cycle.
// When the use clock reaches its top, a renumbering pass runs between decide and write.
// The frame scan and the renumbering pass walk one frame per cycle through the RAM read port.
// rst (synchronous) empties all frames, clears the fault count, sets frames_in_use to 16.
`include "lru_page_replacement_macros.svh"

module lru_page_replacement (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lru_pr_pkg::PAGE_W-1:0] page_number,
  input  logic                         restart,
  input  logic                         cfg_we,
  input  logic [lru_pr_pkg::CFG_W-1:0]  cfg_wdata,
  output logic                         busy,
  output logic                         done,
  output logic                         hit,
  output logic [lru_pr_pkg::FRAME_W-1:0] frame_index,
  output logic                         evicted_valid,
  output logic [lru_pr_pkg::PAGE_W-1:0] evicted_page,
  output logic [lru_pr_pkg::COUNT_W-1:0] fault_count
);

  import lru_pr_pkg::*;

  // Sequencer: scan the frames, pick the slot, optionally renumber the
  // time stamps, then commit the reference.
  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_SCAN     = 7'b0000010,
    ST_DECIDE   = 7'b0000100,
    ST_RN_LOAD  = 7'b0001000,
    ST_RN_SCAN  = 7'b0010000,
    ST_RN_WRITE = 7'b0100000,
    ST_WRITE    = 7'b1000000
  } state_t;

  state_t state;

  // Control registers
  logic [CFG_W-1:0]      frames_in_use;
  logic [MAX_FRAMES-1:0] valid;
  logic [STAMP_W-1:0]    use_clock;
  logic [COUNT_W-1:0]    fault_total;
  logic [CNT_W-1:0]      cnt;
  logic [FRAME_W-1:0]    a_idx;
  logic [CNT_W-1:0]      n_cnt;

  // Per-item working registers
  logic [PAGE_W-1:0]     key;
  logic                  hit_found;
  logic [FRAME_W-1:0]    hit_idx;
  logic                  empty_found;
  logic [FRAME_W-1:0]    empty_idx;
  logic                  vic_set;
  logic [FRAME_W-1:0]    vic_idx;
  logic [PAGE_W-1:0]     vic_page;
  logic [STAMP_W-1:0]    best_stamp;
  logic [STAMP_W-1:0]    a_stamp;
  logic [CNT_W-1:0]      rank_acc;
  logic [CNT_W-1:0]      rank [MAX_FRAMES];
  logic                  hit_q;
  logic                  evict_q;
  logic [PAGE_W-1:0]     ev_page_q;
  logic [FRAME_W-1:0]    slot;

  // RAM ports and shared datapath
  logic [FRAME_W-1:0]    rd_addr;
  logic [PAGE_W-1:0]     page_rd;
  logic [STAMP_W-1:0]    time_rd;
  logic                  page_we;
  logic                  time_we;
  logic [FRAME_W-1:0]    time_wr_addr;
  logic [STAMP_W-1:0]    time_wr_data;
  logic [STAMP_W-1:0]    cmp_ref;
  logic                  lt;
  logic [CNT_W-1:0]      lim;
  logic [CNT_W-1:0]      cnt_m1;
  logic [FRAME_W-1:0]    idx;
  logic                  rank_inc;
  logic [CNT_W-1:0]      rank_sum;

  lru_pr_ram #(.WIDTH(PAGE_W), .DEPTH(MAX_FRAMES)) u_page_ram (
    .clk     (clk),
    .wr_en   (page_we),
    .wr_addr (slot),
    .wr_data (key),
    .rd_addr (rd_addr),
    .rd_data (page_rd)
  );

  lru_pr_ram #(.WIDTH(STAMP_W), .DEPTH(MAX_FRAMES)) u_time_ram (
    .clk     (clk),
    .wr_en   (time_we),
    .wr_addr (time_wr_addr),
    .wr_data (time_wr_data),
    .rd_addr (rd_addr),
    .rd_data (time_rd)
  );

  assign lim    = clamp_limit(frames_in_use);
  // Read data comes in the cycle after its address: cnt-1 is the frame being examined.
  assign cnt_m1 = cnt - CNT_W'(1);
  assign idx    = cnt_m1[FRAME_W-1:0];

  // One shared stamp comparator: victim search in the scan, ranking in renumber.
  assign cmp_ref = (state == ST_SCAN) ? best_stamp : a_stamp;
  assign lt      = time_rd < cmp_ref;

  // Count valid frames older than frame a; the slot being refilled is left out,
  // it takes the newest stamp right after the pass.
  assign rank_inc = (cnt != '0) && valid[idx] && (idx != slot) && valid[a_idx] && lt;
  assign rank_sum = rank_acc + CNT_W'(rank_inc);

  always_comb begin
    unique case (state)
      ST_SCAN, ST_RN_SCAN: rd_addr = cnt[FRAME_W-1:0];
      ST_RN_LOAD:          rd_addr = a_idx;
      default:             rd_addr = '0;
    endcase
  end

  assign time_we      = (state == ST_RN_WRITE) || (state == ST_WRITE);
  assign time_wr_addr = (state == ST_RN_WRITE) ? cnt[FRAME_W-1:0] : slot;
  assign time_wr_data = (state == ST_RN_WRITE) ? STAMP_W'(rank[cnt[FRAME_W-1:0]])
                                               : use_clock;
  assign page_we      = (state == ST_WRITE) && !hit_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      done          <= 1'b0;
      frames_in_use <= CFG_RESET;
      valid         <= '0;
      use_clock     <= '0;
      fault_total   <= '0;
      cnt           <= '0;
      a_idx         <= '0;
      n_cnt         <= '0;
    end else begin
      if (cfg_we) begin
        frames_in_use <= cfg_wdata;
      end
      done <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (start) begin
            key         <= page_number;
            // Restart empties the frames before this reference is looked up.
            if (restart) begin
              valid       <= '0;
              use_clock   <= '0;
              fault_total <= '0;
            end
            cnt         <= '0;
            hit_found   <= 1'b0;
            empty_found <= 1'b0;
            vic_set     <= 1'b0;
            state       <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          if (cnt != '0) begin
            if (valid[idx]) begin
              if (!hit_found && page_rd == key) begin
                hit_found <= 1'b1;
                hit_idx   <= idx;
              end
              // Strict compare: on equal stamps keep the lower frame.
              if (!vic_set || lt) begin
                vic_set    <= 1'b1;
                vic_idx    <= idx;
                vic_page   <= page_rd;
                best_stamp <= time_rd;
              end
            end else if (!empty_found) begin
              empty_found <= 1'b1;
              empty_idx   <= idx;
            end
          end
          if (cnt == lim) begin
            state <= ST_DECIDE;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end

        ST_DECIDE: begin
          hit_q   <= hit_found;
          evict_q <= !hit_found && !empty_found;
          if (hit_found) begin
            slot <= hit_idx;
          end else if (empty_found) begin
            slot <= empty_idx;
          end else begin
            slot <= vic_idx;
          end
          ev_page_q <= (!hit_found && !empty_found) ? vic_page : '0;
          if (!hit_found && fault_total != '1) begin
            fault_total <= fault_total + COUNT_W'(1);
          end
          // Renumber the stamps before the clock would wrap.
          if (use_clock == '1) begin
            a_idx <= '0;
            n_cnt <= '0;
            state <= ST_RN_LOAD;
          end else begin
            state <= ST_WRITE;
          end
        end

        ST_RN_LOAD: begin
          cnt      <= '0;
          rank_acc <= '0;
          state    <= ST_RN_SCAN;
        end

        ST_RN_SCAN: begin
          if (cnt == '0) begin
            a_stamp <= time_rd;
          end
          rank_acc <= rank_sum;
          if (cnt == CNT_W'(MAX_FRAMES)) begin
            rank[a_idx] <= rank_sum;
            if (valid[a_idx] || a_idx == slot) begin
              n_cnt <= n_cnt + CNT_W'(1);
            end
            if (a_idx == FRAME_W'(MAX_FRAMES - 1)) begin
              cnt   <= '0;
              state <= ST_RN_WRITE;
            end else begin
              a_idx <= a_idx + FRAME_W'(1);
              state <= ST_RN_LOAD;
            end
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end

        ST_RN_WRITE: begin
          if (cnt == CNT_W'(MAX_FRAMES - 1)) begin
            use_clock <= STAMP_W'(n_cnt);
            state     <= ST_WRITE;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end

        ST_WRITE: begin
          // Stamp goes to the time RAM this cycle, the page too on a miss; raise the strobe.
          use_clock   <= use_clock + STAMP_W'(1);
          valid[slot] <= 1'b1;
          done        <= 1'b1;
          state       <= ST_IDLE;
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state != ST_IDLE);
  assign hit           = hit_q;
  assign frame_index   = slot;
  assign evicted_valid = evict_q;
  assign evicted_page  = ev_page_q;
  assign fault_count   = fault_total;

  `LRU_CHECK_NOW(a_done_idle, done, !busy, "result strobe while busy")
  `LRU_CHECK_NEXT(a_start_busy, start && !busy, busy && !done, "start transfer not taken")
  `LRU_CHECK_NOW(a_evict_miss, done && evicted_valid, !hit, "eviction reported on a hit")
  `LRU_CHECK_NOW(a_scan_bound, state == ST_SCAN, cnt <= lim, "scan ran past frame limit")

endmodule

FILE: bench/lru_checker.sv
module lru_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [lru_pr_pkg::PAGE_W-1:0]  page_number,
  input  logic                          restart,
  input  logic                          cfg_we,
  input  logic [lru_pr_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                          done,
  input  logic                          hit,
  input  logic [lru_pr_pkg::FRAME_W-1:0] frame_index,
  input  logic                          evicted_valid,
  input  logic [lru_pr_pkg::PAGE_W-1:0]  evicted_page,
  input  logic [lru_pr_pkg::COUNT_W-1:0] fault_count,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import lru_pr_pkg::*;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
    logic               ev_valid;
    logic [PAGE_W-1:0]  ev_page;
    logic [COUNT_W-1:0] faults;
  } ref_outcome_t;

  // Shadow copy of the frame table
  logic [PAGE_W-1:0]  page_of  [MAX_FRAMES];
  logic               held     [MAX_FRAMES];
  logic [STAMP_W-1:0] stamp_of [MAX_FRAMES];
  logic [STAMP_W-1:0] use_clk;
  logic [COUNT_W-1:0] fault_tally;
  logic [CFG_W-1:0]   frames_reg;

  ref_outcome_t outcome_q[$];
  int fails  = 0;
  int queued = 0;

  assign fail_count = fails;
  assign pending    = queued;

  function automatic void empty_frames();
    for (int i = 0; i < MAX_FRAMES; i++) begin
      page_of[i]  = '0;
      held[i]     = 1'b0;
      stamp_of[i] = '0;
    end
    use_clk     = '0;
    fault_tally = '0;
  endfunction

  // Hand out the next recency stamp; squeeze the valid stamps to 0..n-1
  // first when the clock has run to its top.
  function automatic logic [STAMP_W-1:0] next_stamp();
    logic [STAMP_W-1:0] rank [MAX_FRAMES];
    logic [STAMP_W-1:0] n;
    logic [STAMP_W-1:0] t;
    if (use_clk == '1) begin
      n = '0;
      for (int a = 0; a < MAX_FRAMES; a++) begin
        rank[a] = '0;
        if (held[a]) begin
          for (int b = 0; b < MAX_FRAMES; b++)
            if (held[b] && stamp_of[b] < stamp_of[a]) rank[a] = rank[a] + 1'b1;
          n = n + 1'b1;
        end
      end
      for (int a = 0; a < MAX_FRAMES; a++) stamp_of[a] = held[a] ? rank[a] : '0;
      use_clk = n;
    end
    t = use_clk;
    use_clk = use_clk + 1'b1;
    return t;
  endfunction

  function automatic ref_outcome_t resolve_reference(input logic [PAGE_W-1:0] page,
                                                     input logic fresh);
    ref_outcome_t r;
    int lim, slot, spare, victim;
    if (fresh) empty_frames();
    lim = int'(frames_reg);
    if (lim < 1) lim = 1;
    if (lim > MAX_FRAMES) lim = MAX_FRAMES;
    slot   = -1;
    spare  = -1;
    victim = -1;
    r      = '0;
    for (int i = 0; i < lim; i++) begin
      if (held[i]) begin
        if (slot < 0 && page_of[i] == page) slot = i;
      end else if (spare < 0) begin
        spare = i;
      end
    end
    if (slot >= 0) begin
      r.hit = 1'b1;
    end else begin
      if (spare >= 0) begin
        slot = spare;
        held[slot] = 1'b1;
      end else begin
        for (int i = 0; i < lim; i++)
          if (victim < 0 || stamp_of[i] < stamp_of[victim]) victim = i;
        slot = victim;
        r.ev_valid = 1'b1;
        r.ev_page  = page_of[slot];
      end
      page_of[slot] = page;
      if (fault_tally != '1) fault_tally = fault_tally + 1'b1;
    end
    stamp_of[slot] = next_stamp();
    r.frame  = FRAME_W'(slot);
    r.faults = fault_tally;
    return r;
  endfunction

  function automatic void flag_field(input string field, input logic [31:0] want,
                                     input logic [31:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    ref_outcome_t want;
    if (rst) begin
      empty_frames();
      frames_reg = CFG_RESET;
      outcome_q.delete();
    end else begin
      if (done === 1'b1) begin
        if (outcome_q.size() == 0) begin
          fails++;
          $display("%0t: result strobe with nothing outstanding", $time);
        end else begin
          want = outcome_q.pop_front();
          flag_field("hit", 32'(want.hit), 32'(hit));
          flag_field("frame_index", 32'(want.frame), 32'(frame_index));
          flag_field("evicted_valid", 32'(want.ev_valid), 32'(evicted_valid));
          flag_field("evicted_page", 32'(want.ev_page), 32'(evicted_page));
          flag_field("fault_count", 32'(want.faults), 32'(fault_count));
        end
      end
      if (cfg_we) frames_reg = cfg_wdata;
      if (start && !busy) outcome_q.push_back(resolve_reference(page_number, restart));
    end
    queued = outcome_q.size();
  end

endmodule

FILE: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lru_pr_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [PAGE_W-1:0]  page_number = '0;
  logic               restart = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata = '0;
  logic               busy;
  logic               done;
  logic               hit;
  logic [FRAME_W-1:0] frame_index;
  logic               evicted_valid;
  logic [PAGE_W-1:0]  evicted_page;
  logic [COUNT_W-1:0] fault_count;
  int                 fail_count;
  int                 pending;

  // Settings swept by the random part; the extremes come first.
  logic [CFG_W-1:0]   phase_cfg [6];
  int                 burst_left;
  int                 span;
  logic [PAGE_W-1:0]  base;
  logic [PAGE_W-1:0]  pg;
  logic               gappy;

  initial begin
    forever #5 clk = ~clk;
  end

  lru_page_replacement i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .page_number   (page_number),
    .restart       (restart),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .busy          (busy),
    .done          (done),
    .hit           (hit),
    .frame_index   (frame_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_count   (fault_count)
  );

  lru_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .page_number   (page_number),
    .restart       (restart),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .done          (done),
    .hit           (hit),
    .frame_index   (frame_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_count   (fault_count),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // Present one page reference and hold it until the transfer happens.
  // Start stays high on return so a following reference goes back to back.
  task automatic issue_ref(input logic [PAGE_W-1:0] page, input logic fresh);
    @(negedge clk);
    start       <= 1'b1;
    page_number <= page;
    restart     <= fresh;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start and toggle the payload meanwhile; it must be ignored.
  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start       <= 1'b0;
      page_number <= PAGE_W'($urandom);
      restart     <= 1'($urandom);
    end
  endtask

  // Drop start and wait until every outstanding result has come back.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Change the frame count only while the block is idle.
  task automatic write_frames(input logic [CFG_W-1:0] value);
    drain();
    repeat (4) @(negedge clk);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Hard stop in case the block hangs.
  initial begin
    #30_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    // Hold reset at the start, then release it for good.
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed part, frame count at its reset value of 16.
    // Start a string with a restart, touch both page extremes, then hit.
    issue_ref(8'h00, 1'b1);
    issue_ref(8'hFF, 1'b0);
    issue_ref(8'h00, 1'b0);
    issue_ref(8'h55, 1'b0);
    issue_ref(8'hAA, 1'b0);
    issue_ref(8'hFF, 1'b0);
    // Lower the limit to two: frames above keep their pages but drop out of
    // lookup, so these references evict the older of frames 0 and 1.
    write_frames(5'd2);
    issue_ref(8'h55, 1'b0);
    issue_ref(8'h0F, 1'b0);
    // Zero acts as one frame.
    write_frames(5'd0);
    issue_ref(8'hF0, 1'b0);
    issue_ref(8'hF0, 1'b0);
    // Above the maximum acts as sixteen; the parked frames come back.
    write_frames(5'd31);
    issue_ref(8'hAA, 1'b0);
    issue_ref(8'h0F, 1'b0);
    issue_ref(8'h33, 1'b0);
    // Restart in the middle of a string.
    issue_ref(8'h80, 1'b1);
    issue_ref(8'h01, 1'b0);
    issue_ref(8'h80, 1'b0);

    // Random part: mostly a small working set so hits and LRU evictions
    // dominate, with some fully random pages and a rare restart.
    phase_cfg[0] = 5'd16;
    phase_cfg[1] = 5'd1;
    phase_cfg[2] = 5'd31;
    phase_cfg[3] = 5'd0;
    phase_cfg[4] = CFG_W'($urandom_range(2, 15));
    phase_cfg[5] = CFG_W'($urandom_range(0, 31));
    for (int ph = 0; ph < 6; ph++) begin
      write_frames(phase_cfg[ph]);
      span = (phase_cfg[ph] == '0) ? 1 :
             (int'(phase_cfg[ph]) > MAX_FRAMES) ? MAX_FRAMES : int'(phase_cfg[ph]);
      base  = PAGE_W'($urandom);
      gappy = (ph != 2);   // one phase runs back to back throughout
      burst_left = 0;
      for (int n = 0; n < 92; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          if (gappy) hold_off($urandom_range(1, 8));
        end
        burst_left--;
        if ($urandom_range(0, 9) < 7) pg = base + PAGE_W'($urandom_range(0, span + 2));
        else pg = PAGE_W'($urandom);
        issue_ref(pg, $urandom_range(0, 29) == 0);
      end
    end

    // Let the last results land, then give the verdict.
    drain();
    repeat (24) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
